/* rtl/jaet_pkg.sv */
// Package for the joystick event translator: item types, codes and defaults.
// No dependencies; the row store, event generator and top level import it.
`timescale 1ns / 1ps
`default_nettype none

package jaet_pkg;

  localparam int unsigned SLOTS_DEF   = 4;
  localparam int unsigned AXES_DEF    = 8;
  localparam int unsigned BUTTONS_DEF = 16;

  localparam int unsigned ID_W     = 16;
  localparam int unsigned CUTOFF_W = 15;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    MODE_AXIS   = 2'd0,
    MODE_BUTTON = 2'd1,
    MODE_CLEAR  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    DIR_NEUTRAL = 2'd0,
    DIR_NEG     = 2'd1,
    DIR_POS     = 2'd2
  } dir_e;

  typedef enum logic [1:0] {
    CFG_DEAD_ZONE   = 2'd0,
    CFG_AXIS_BASE   = 2'd1,
    CFG_BUTTON_BASE = 2'd2,
    CFG_SLOT_STRIDE = 2'd3
  } cfg_idx_e;

  // What an accepted item turns into once its indices are checked
  typedef enum logic [1:0] {
    K_NONE   = 2'd0,
    K_AXIS   = 2'd1,
    K_BUTTON = 2'd2,
    K_CLEAR  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0]        mode;
    logic [7:0]        slot;
    logic [7:0]        axis_index;
    logic signed [15:0] axis_value;
    logic [7:0]        button_index;
    logic              button_pressed;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0] event_id;
    logic            pressed;
    logic            last;
  } out_item_t;

  // Status from the event generator towards the pipeline control
  typedef struct packed {
    logic      has_res;
    out_item_t res;
    logic      wr_en;
  } ev_t;

endpackage

`default_nettype wire

/* rtl/jaet_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module jaet_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/jaet_row_store.sv */
// Direction store: one RAM row per slot, row valid bits and write forwarding.
// Depends on jaet_pkg and jaet_ram.
`timescale 1ns / 1ps
`default_nettype none

module jaet_row_store import jaet_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEF,
  parameter int unsigned AXES  = AXES_DEF,
  localparam int unsigned ROW_W   = 2 * AXES,
  localparam int unsigned SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               rd_en_i,
  input  wire logic [SLOT_AW-1:0] rd_addr_i,
  input  wire logic [SLOT_AW-1:0] cur_addr_i,
  output logic      [ROW_W-1:0]   cur_row_o,
  input  wire logic               wr_en_i,
  input  wire logic [SLOT_AW-1:0] wr_addr_i,
  input  wire logic [ROW_W-1:0]   wr_row_i
);

  logic [ROW_W-1:0]   rdata;
  logic [SLOTS-1:0]   row_vld_q;
  logic               lw_vld_q;
  logic [SLOT_AW-1:0] lw_addr_q;
  logic [ROW_W-1:0]   lw_row_q;

  jaet_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en_i),
    .waddr_i (wr_addr_i),
    .wdata_i (wr_row_i),
    .re_i    (rd_en_i),
    .raddr_i (rd_addr_i),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      lw_vld_q  <= 1'b0;
    end else if (wr_en_i) begin
      row_vld_q[wr_addr_i] <= 1'b1;
      lw_vld_q             <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      lw_addr_q <= wr_addr_i;
      lw_row_q  <= wr_row_i;
    end
  end

  // The latest write wins over a read that raced it; unwritten rows are neutral
  always_comb begin
    if (lw_vld_q && (lw_addr_q == cur_addr_i)) begin
      cur_row_o = lw_row_q;
    end else if (row_vld_q[cur_addr_i]) begin
      cur_row_o = rdata;
    end else begin
      cur_row_o = '0;
    end
  end

endmodule

`default_nettype wire

/* rtl/jaet_event_gen.sv */
// Result and write-back generation for the item in the execute stage.
// Depends on jaet_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jaet_event_gen import jaet_pkg::*; #(
  parameter int unsigned AXES = AXES_DEF,
  localparam int unsigned ROW_W   = 2 * AXES,
  localparam int unsigned AXIS_AW = (AXES > 1) ? $clog2(AXES) : 1
) (
  input  wire kind_e                kind_i,
  input  wire logic                 phase_i,
  input  wire logic [AXIS_AW-1:0]   axis_i,
  input  wire dir_e                 new_dir_i,
  input  wire logic [ID_W-1:0]      slot_off_i,
  input  wire logic [7:0]           button_i,
  input  wire logic                 bpress_i,
  input  wire logic [ID_W-1:0]      axis_base_i,
  input  wire logic [ID_W-1:0]      button_base_i,
  input  wire logic [ROW_W-1:0]     row_i,
  output ev_t                       ev_o,
  output logic      [ROW_W-1:0]     wr_row_o
);

  logic [1:0]      old_dir;
  logic            changed;
  logic            rel_first;
  dir_e            emit_dir;
  logic [ID_W-1:0] axis_id;
  logic [ID_W-1:0] button_id;

  assign old_dir   = row_i[{axis_i, 1'b0} +: 2];
  assign changed   = (old_dir != new_dir_i);
  // release of the old direction goes first, unless there is none
  assign rel_first = !phase_i && (old_dir != DIR_NEUTRAL);
  assign emit_dir  = rel_first ? dir_e'(old_dir) : new_dir_i;
  assign axis_id   = axis_base_i + slot_off_i
                   + ID_W'({axis_i, (emit_dir == DIR_POS)});
  assign button_id = button_base_i + slot_off_i + ID_W'(button_i);

  always_comb begin
    ev_o     = '0;
    wr_row_o = row_i;
    wr_row_o[{axis_i, 1'b0} +: 2] = new_dir_i;
    case (kind_i)
      K_AXIS: begin
        ev_o.has_res      = changed;
        ev_o.wr_en        = changed;
        ev_o.res.event_id = axis_id;
        ev_o.res.pressed  = !rel_first;
        ev_o.res.last     = !rel_first || (new_dir_i == DIR_NEUTRAL);
      end
      K_BUTTON: begin
        ev_o.has_res      = 1'b1;
        ev_o.res.event_id = button_id;
        ev_o.res.pressed  = bpress_i;
        ev_o.res.last     = 1'b1;
      end
      K_CLEAR: begin
        ev_o.wr_en = 1'b1;
        wr_row_o   = '0;
      end
      default: begin
        ev_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/joystick_axis_button_event_translator.sv */
// Top level of the joystick event translator: config registers, decode,
// execute stage and output register. Depends on jaet_pkg, jaet_row_store,
// jaet_event_gen.
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake             Payload
// in       sink       in_valid_i/in_stall_o   in_item_i  (in_item_t)
// out      source     out_valid_o/out_stall_i out_item_o (out_item_t)
// cfg      sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// An item enters decode and issues its row read in the cycle it is accepted;
// the next cycle it executes against the row, writing it back as it leaves.
// A new item is taken every cycle, except that an axis change with both a
// release and a press holds execute until that press is sent. Forwarding of
// the last row write covers back-to-back items on the same slot. Reset
// clears the row valid bits at once, so no clearing pass is run. A stalled
// output register holds execute, and execute, once held, stalls the input.

module joystick_axis_button_event_translator import jaet_pkg::*; #(
  parameter int unsigned SLOTS   = SLOTS_DEF,
  parameter int unsigned AXES    = AXES_DEF,
  parameter int unsigned BUTTONS = BUTTONS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire in_item_t              in_item_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output out_item_t                  out_item_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned ROW_W   = 2 * AXES;
  localparam int unsigned SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned AXIS_AW = (AXES > 1) ? $clog2(AXES) : 1;
  localparam logic [8:0]  SLOTS_L   = 9'(SLOTS);
  localparam logic [8:0]  AXES_L    = 9'(AXES);
  localparam logic [8:0]  BUTTONS_L = 9'(BUTTONS);

  // configuration registers
  logic [CUTOFF_W-1:0] cutoff_q;
  logic [ID_W-1:0]     axis_base_q, button_base_q, stride_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q      <= '0;
      axis_base_q   <= '0;
      button_base_q <= '0;
      stride_q      <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_DEAD_ZONE:   cutoff_q      <= cfg_data_i[CUTOFF_W-1:0];
        CFG_AXIS_BASE:   axis_base_q   <= cfg_data_i;
        CFG_BUTTON_BASE: button_base_q <= cfg_data_i;
        CFG_SLOT_STRIDE: stride_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // decode at acceptance
  logic            accept;
  logic            slot_ok, axis_ok, button_ok;
  logic            neg;
  logic [15:0]     mag;
  kind_e           kind_d;
  dir_e            dir_d;

  assign slot_ok   = {1'b0, in_item_i.slot} < SLOTS_L;
  assign axis_ok   = {1'b0, in_item_i.axis_index} < AXES_L;
  assign button_ok = {1'b0, in_item_i.button_index} < BUTTONS_L;
  assign neg       = in_item_i.axis_value[15];
  assign mag       = neg ? (~in_item_i.axis_value + 16'd1) : in_item_i.axis_value;

  always_comb begin
    // full-scale negative always lies beyond a 15-bit cutoff
    if (mag <= {1'b0, cutoff_q}) begin
      dir_d = DIR_NEUTRAL;
    end else begin
      dir_d = neg ? DIR_NEG : DIR_POS;
    end
  end

  always_comb begin
    kind_d = K_NONE;
    case (in_item_i.mode)
      MODE_AXIS:   kind_d = (slot_ok && axis_ok) ? K_AXIS : K_NONE;
      MODE_BUTTON: kind_d = (slot_ok && button_ok) ? K_BUTTON : K_NONE;
      MODE_CLEAR:  kind_d = slot_ok ? K_CLEAR : K_NONE;
      default:     kind_d = K_NONE;
    endcase
  end

  // execute stage
  logic               s1_vld_q, s1_vld_d;
  logic               phase_q, phase_d;
  kind_e              kind_q;
  dir_e               dir_q;
  logic [SLOT_AW-1:0] slot_q;
  logic [AXIS_AW-1:0] axis_q;
  logic [ID_W-1:0]    slot_off_q;
  logic [7:0]         button_q;
  logic               bpress_q;

  ev_t               ev;
  logic [ROW_W-1:0]  cur_row, wr_row;
  logic              emit_ok, emit, s1_done, wr_en;

  assign emit_ok    = !out_valid_o || !out_stall_i;
  assign emit       = s1_vld_q && ev.has_res && emit_ok;
  assign s1_done    = s1_vld_q && (!ev.has_res || (emit_ok && ev.res.last));
  assign in_stall_o = s1_vld_q && !s1_done;
  assign accept     = in_valid_i && !in_stall_o;
  assign wr_en      = s1_done && ev.wr_en;

  always_comb begin
    s1_vld_d = s1_vld_q;
    phase_d  = phase_q;
    if (s1_done) begin
      s1_vld_d = 1'b0;
      phase_d  = 1'b0;
    end else if (emit) begin
      // first of two results sent; advance to the press
      phase_d = 1'b1;
    end
    if (accept) begin
      s1_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      phase_q  <= 1'b0;
    end else begin
      s1_vld_q <= s1_vld_d;
      phase_q  <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q     <= kind_d;
      dir_q      <= dir_d;
      slot_q     <= in_item_i.slot[SLOT_AW-1:0];
      axis_q     <= in_item_i.axis_index[AXIS_AW-1:0];
      slot_off_q <= ID_W'(in_item_i.slot * stride_q);
      button_q   <= in_item_i.button_index;
      bpress_q   <= in_item_i.button_pressed;
    end
  end

  jaet_row_store #(
    .SLOTS (SLOTS),
    .AXES  (AXES)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept),
    .rd_addr_i  (in_item_i.slot[SLOT_AW-1:0]),
    .cur_addr_i (slot_q),
    .cur_row_o  (cur_row),
    .wr_en_i    (wr_en),
    .wr_addr_i  (slot_q),
    .wr_row_i   (wr_row)
  );

  jaet_event_gen #(
    .AXES (AXES)
  ) u_gen (
    .kind_i        (kind_q),
    .phase_i       (phase_q),
    .axis_i        (axis_q),
    .new_dir_i     (dir_q),
    .slot_off_i    (slot_off_q),
    .button_i      (button_q),
    .bpress_i      (bpress_q),
    .axis_base_i   (axis_base_q),
    .button_base_i (button_base_q),
    .row_i         (cur_row),
    .ev_o          (ev),
    .wr_row_o      (wr_row)
  );

  // output register: load on emit, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (emit) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_item_o <= ev.res;
    end
  end

`ifndef NO_ASSERTIONS
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_vld_q |-> !in_stall_o)
    else $error("input stalled with empty execute stage");

  a_write_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> s1_done && ((kind_q == K_AXIS) || (kind_q == K_CLEAR)))
    else $error("row written outside an axis or clear commit");

  a_second_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && !ev.res.last |=> s1_vld_q && phase_q && out_valid_o)
    else $error("second result not held after first");

  a_second_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q && emit |-> ev.res.last && ev.res.pressed)
    else $error("second result is not the final press");
`endif

endmodule

`default_nettype wire
